// ===== design/diode_companion_eval_macros.svh =====
// Assertion macros shared by the diode companion evaluator.
`ifndef DIODE_COMPANION_EVAL_MACROS_SVH
`define DIODE_COMPANION_EVAL_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DCE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DCE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/dce_pkg.sv =====
// Constants, tables and helper functions of the diode companion evaluator.
package dce_pkg;

  localparam int EXP_TABLE_BITS_DEF = 6;

  localparam logic [39:0] SAT_CURRENT_RST = 40'd2520000;
  localparam logic [23:0] EXP_SCALE_RST   = 24'd1438600;

  localparam logic [28:0] LOG2E_K   = 29'd406082553;
  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam logic [30:0] Q30_ONE   = 31'h4000_0000;
  localparam logic [29:0] Q30_HALF  = 30'h2000_0000;
  localparam logic [19:0] RECIP_SIX = 20'd699051;
  localparam logic [30:0] MANT_MAX  = 31'h7FFF_FFFF;
  localparam logic [62:0] LIMIT63   = {63{1'b1}};

  localparam logic [7:0] CFG_SAT_CURRENT = 8'd0;
  localparam logic [7:0] CFG_EXP_SCALE   = 8'd1;
  localparam logic [7:0] CFG_ANODE_GND   = 8'd2;
  localparam logic [7:0] CFG_CATHODE_GND = 8'd3;

  typedef logic [30:0] mant_t;

  // 2^(2^-k) in Q30.
  function automatic mant_t root_two(input int k);
    mant_t r;
    case (k)
      1: r = 31'd1518500250;
      2: r = 31'd1276901417;
      3: r = 31'd1170923762;
      4: r = 31'd1121280436;
      5: r = 31'd1097253708;
      6: r = 31'd1085434106;
      7: r = 31'd1079572136;
      8: r = 31'd1076653033;
      9: r = 31'd1075196444;
      10: r = 31'd1074468887;
      default: r = Q30_ONE;
    endcase
    return r;
  endfunction

  // Scales x by 2^k; the top bit of the result flags a value of 2^64 or more.
  function automatic logic [64:0] shift_sat(input logic [94:0] x, input logic signed [15:0] k);
    logic [158:0] s;
    logic         ovf;
    logic [15:0]  r;
    s   = '0;
    ovf = 1'b0;
    r   = 16'(-k);
    if (!k[15]) begin
      if (k >= 16'sd64) begin
        ovf = |x;
      end else begin
        s = {64'b0, x} << k[5:0];
      end
    end else if (r < 16'd95) begin
      s = {64'b0, x} >> r[6:0];
    end
    ovf = ovf | (|s[158:64]);
    return {ovf, s[63:0]};
  endfunction

endpackage

// ===== design/diode_companion_eval.sv =====
// Pipelined Shockley diode evaluator: junction voltage, current and conductance.
// The input channel takes one request per cycle carrying the anode and cathode
// node voltages in microvolts. The result channel returns the junction voltage,
// the diode current in femtoamps and the small-signal conductance in
// femtosiemens, with tuser raised when either value has been clipped.
// The configuration channel writes the saturation current, the exponent scale
// and the two grounding flags; it is always ready and should only be used while
// no request is in flight.
// The pipeline has one stage per root-of-two table bit plus the fixed stages of the
// exponent setup, the polynomial, the wide current multiply and the scaling.
// Throughput is one request per cycle while the receiver keeps out_tready high.
// Every stage holds its request while the stage after it is full and held, so
// when the receiver stalls the pipeline fills up behind the output register and
// input is still taken until no empty stage remains.
// Reset empties the pipeline and loads the configuration registers with their
// default values.
`include "diode_companion_eval_macros.svh"

module diode_companion_eval
  import dce_pkg::*;
#(
  parameter int EXP_TABLE_BITS = EXP_TABLE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [47:0]  in_tdata,   // anode_voltage, cathode_voltage
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [151:0] out_tdata,  // junction_voltage, diode_current, small_signal_conductance
  output logic         out_tuser,  // saturated
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [39:0]  cfg_data
);

  localparam int T       = EXP_TABLE_BITS;
  localparam int RW      = 30 - T;
  localparam int T2W     = 2 * RW - 30;
  localparam int T3W     = (3 * RW - 60 >= 1) ? 3 * RW - 60 : 1;
  localparam int P3W     = T3W + 30;
  localparam int ST_TAB  = 4;
  localparam int ST_P0   = T + 4;
  localparam int ST_P1   = T + 5;
  localparam int ST_P2   = T + 6;
  localparam int ST_P3   = T + 7;
  localparam int ST_P4   = T + 8;
  localparam int ST_P5   = T + 9;
  localparam int ST_M0   = T + 10;
  localparam int ST_M1   = T + 11;
  localparam int ST_M2   = T + 12;
  localparam int ST_M3   = T + 13;
  localparam int ST_M4   = T + 14;
  localparam int ST_OUT  = T + 15;
  localparam int NS      = T + 16;

  logic [39:0] is_r;
  logic [23:0] es_r;
  logic        a_gnd_r;
  logic        c_gnd_r;

  logic [NS-1:0] v_r;
  logic [NS-1:0] en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      is_r    <= SAT_CURRENT_RST;
      es_r    <= EXP_SCALE_RST;
      a_gnd_r <= 1'b0;
      c_gnd_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SAT_CURRENT: is_r <= cfg_data;
        CFG_EXP_SCALE: es_r <= cfg_data[23:0];
        CFG_ANODE_GND: a_gnd_r <= cfg_data[0];
        CFG_CATHODE_GND: c_gnd_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    en[NS-1] = !v_r[NS-1] || out_tready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_tvalid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  assign in_tready  = en[0];
  assign out_tvalid = v_r[NS-1];

  // Junction voltage and its magnitude.
  logic signed [23:0] va;
  logic signed [23:0] vc;
  logic signed [24:0] vj;
  logic signed [24:0] s1_vj_r;
  logic               s1_neg_r;
  logic [23:0]        s1_mag_r;

  assign va = a_gnd_r ? 24'sd0 : $signed(in_tdata[23:0]);
  assign vc = c_gnd_r ? 24'sd0 : $signed(in_tdata[47:24]);
  assign vj = {va[23], va} - {vc[23], vc};

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_vj_r  <= vj;
      s1_neg_r <= vj[24];
      s1_mag_r <= vj[24] ? 24'(-vj) : vj[23:0];
    end
  end

  logic signed [24:0] s2_vj_r;
  logic               s2_neg_r;
  logic [47:0]        s2_p_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_vj_r  <= s1_vj_r;
      s2_neg_r <= s1_neg_r;
      s2_p_r   <= 48'(s1_mag_r) * 48'(es_r);
    end
  end

  logic signed [24:0] s3_vj_r;
  logic               s3_neg_r;
  logic [52:0]        s3_a_r;
  logic [52:0]        s3_b_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_vj_r  <= s2_vj_r;
      s3_neg_r <= s2_neg_r;
      s3_a_r   <= 53'(s2_p_r[47:24]) * 53'(LOG2E_K);
      s3_b_r   <= 53'(s2_p_r[23:0]) * 53'(LOG2E_K);
    end
  end

  // Split the base-2 exponent into an integer shift and a Q24 fraction.
  logic [53:0]        ysum;
  logic [37:0]        m;
  logic [14:0]        mceil;
  logic signed [24:0] s4_vj_r;
  logic signed [15:0] s4_n_r;
  logic [23:0]        s4_u_r;

  assign ysum  = 54'(s3_a_r) + 54'(s3_b_r[52:24]);
  assign m     = ysum[53:16];
  assign mceil = {1'b0, m[37:24]} + 15'(|m[23:0]);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_vj_r <= s3_vj_r;
      s4_n_r  <= s3_neg_r ? -$signed(16'(mceil)) : $signed(16'(m[37:24]));
      s4_u_r  <= s3_neg_r ? 24'(24'd0 - m[23:0]) : m[23:0];
    end
  end

  // One stage per table bit of the fraction.
  mant_t              tf_r  [T];
  logic [23:0]        tu_r  [T];
  logic signed [15:0] tn_r  [T];
  logic signed [24:0] tvj_r [T];

  for (genvar j = 0; j < T; j++) begin : g_tab
    mant_t              f_in;
    logic [23:0]        u_in;
    logic signed [15:0] n_in;
    logic signed [24:0] vj_in;
    logic [61:0]        prod;

    if (j == 0) begin : g_first
      assign f_in  = Q30_ONE;
      assign u_in  = s4_u_r;
      assign n_in  = s4_n_r;
      assign vj_in = s4_vj_r;
    end else begin : g_next
      assign f_in  = tf_r[j-1];
      assign u_in  = tu_r[j-1];
      assign n_in  = tn_r[j-1];
      assign vj_in = tvj_r[j-1];
    end

    assign prod = 62'(f_in) * 62'(root_two(j + 1)) + 62'(Q30_HALF);

    always_ff @(posedge clk) begin
      if (en[ST_TAB+j]) begin
        tf_r[j]  <= u_in[23-j] ? prod[60:30] : f_in;
        tu_r[j]  <= u_in;
        tn_r[j]  <= n_in;
        tvj_r[j] <= vj_in;
      end
    end
  end

  // Cubic polynomial for the remaining fraction bits.
  logic [RW-1:0]      r;
  logic [RW+29:0]     tprod;
  logic [RW-1:0]      p0_t_r;
  mant_t              p0_f_r;
  logic signed [15:0] p0_n_r;
  logic signed [24:0] p0_vj_r;

  assign r     = {tu_r[T-1][23-T:0], 6'b0};
  assign tprod = (RW + 30)'(r) * (RW + 30)'(LN2_Q30) + (RW + 30)'(Q30_HALF);

  always_ff @(posedge clk) begin
    if (en[ST_P0]) begin
      p0_t_r  <= tprod[RW+29:30];
      p0_f_r  <= tf_r[T-1];
      p0_n_r  <= tn_r[T-1];
      p0_vj_r <= tvj_r[T-1];
    end
  end

  logic [2*RW-1:0]    sqprod;
  logic [RW-1:0]      p1_t_r;
  logic [T2W-1:0]     p1_t2_r;
  mant_t              p1_f_r;
  logic signed [15:0] p1_n_r;
  logic signed [24:0] p1_vj_r;

  assign sqprod = (2 * RW)'(p0_t_r) * (2 * RW)'(p0_t_r);

  always_ff @(posedge clk) begin
    if (en[ST_P1]) begin
      p1_t_r  <= p0_t_r;
      p1_t2_r <= sqprod[2*RW-1:30];
      p1_f_r  <= p0_f_r;
      p1_n_r  <= p0_n_r;
      p1_vj_r <= p0_vj_r;
    end
  end

  logic [P3W-1:0]     cuprod;
  logic [RW-1:0]      p2_t_r;
  logic [T2W-1:0]     p2_t2_r;
  logic [T3W-1:0]     p2_t3_r;
  mant_t              p2_f_r;
  logic signed [15:0] p2_n_r;
  logic signed [24:0] p2_vj_r;

  assign cuprod = P3W'(p1_t2_r) * P3W'(p1_t_r);

  always_ff @(posedge clk) begin
    if (en[ST_P2]) begin
      p2_t_r  <= p1_t_r;
      p2_t2_r <= p1_t2_r;
      p2_t3_r <= cuprod[P3W-1:30];
      p2_f_r  <= p1_f_r;
      p2_n_r  <= p1_n_r;
      p2_vj_r <= p1_vj_r;
    end
  end

  logic [40:0]        d6prod;
  logic [30:0]        q;
  logic [30:0]        p3_q_r;
  mant_t              p3_f_r;
  logic signed [15:0] p3_n_r;
  logic signed [24:0] p3_vj_r;

  assign d6prod = 41'(p2_t3_r) * 41'(RECIP_SIX);
  assign q      = Q30_ONE + 31'(p2_t_r) + 31'(p2_t2_r >> 1) + 31'(d6prod[40:22]);

  always_ff @(posedge clk) begin
    if (en[ST_P3]) begin
      p3_q_r  <= q;
      p3_f_r  <= p2_f_r;
      p3_n_r  <= p2_n_r;
      p3_vj_r <= p2_vj_r;
    end
  end

  logic [61:0]        p4_fq_r;
  logic signed [15:0] p4_n_r;
  logic signed [24:0] p4_vj_r;

  always_ff @(posedge clk) begin
    if (en[ST_P4]) begin
      p4_fq_r <= 62'(p3_f_r) * 62'(p3_q_r);
      p4_n_r  <= p3_n_r;
      p4_vj_r <= p3_vj_r;
    end
  end

  logic [62:0]        fround;
  mant_t              p5_f_r;
  logic signed [15:0] p5_n_r;
  logic signed [24:0] p5_vj_r;

  assign fround = 63'(p4_fq_r) + 63'(Q30_HALF);

  always_ff @(posedge clk) begin
    if (en[ST_P5]) begin
      p5_f_r  <= (|fround[62:61]) ? MANT_MAX : fround[60:30];
      p5_n_r  <= p4_n_r;
      p5_vj_r <= p4_vj_r;
    end
  end

  // Saturation current times mantissa, in two partial products.
  logic [50:0]        m0_pl_r;
  logic [50:0]        m0_ph_r;
  logic signed [15:0] m0_n_r;
  logic signed [24:0] m0_vj_r;

  always_ff @(posedge clk) begin
    if (en[ST_M0]) begin
      m0_pl_r <= 51'(is_r[19:0]) * 51'(p5_f_r);
      m0_ph_r <= 51'(is_r[39:20]) * 51'(p5_f_r);
      m0_n_r  <= p5_n_r;
      m0_vj_r <= p5_vj_r;
    end
  end

  logic [70:0]        m1_x_r;
  logic signed [15:0] m1_n_r;
  logic signed [24:0] m1_vj_r;

  always_ff @(posedge clk) begin
    if (en[ST_M1]) begin
      m1_x_r  <= {m0_ph_r, 20'b0} + 71'(m0_pl_r);
      m1_n_r  <= m0_n_r;
      m1_vj_r <= m0_vj_r;
    end
  end

  // Conductance product: current product times exponent scale.
  logic [47:0]        m2_c0_r;
  logic [47:0]        m2_c1_r;
  logic [46:0]        m2_c2_r;
  logic [70:0]        m2_x_r;
  logic signed [15:0] m2_n_r;
  logic signed [24:0] m2_vj_r;

  always_ff @(posedge clk) begin
    if (en[ST_M2]) begin
      m2_c0_r <= 48'(m1_x_r[23:0]) * 48'(es_r);
      m2_c1_r <= 48'(m1_x_r[47:24]) * 48'(es_r);
      m2_c2_r <= 47'(m1_x_r[70:48]) * 47'(es_r);
      m2_x_r  <= m1_x_r;
      m2_n_r  <= m1_n_r;
      m2_vj_r <= m1_vj_r;
    end
  end

  logic [94:0]        m3_xg_r;
  logic [70:0]        m3_x_r;
  logic signed [15:0] m3_kp_r;
  logic signed [15:0] m3_kg_r;
  logic signed [24:0] m3_vj_r;

  always_ff @(posedge clk) begin
    if (en[ST_M3]) begin
      m3_xg_r <= 95'(m2_c0_r) + 95'({m2_c1_r, 24'b0}) + {m2_c2_r, 48'b0};
      m3_x_r  <= m2_x_r;
      m3_kp_r <= m2_n_r - 16'sd30;
      m3_kg_r <= m2_n_r - 16'sd46;
      m3_vj_r <= m2_vj_r;
    end
  end

  logic [64:0]        m4_sp_r;
  logic [64:0]        m4_sg_r;
  logic signed [24:0] m4_vj_r;

  always_ff @(posedge clk) begin
    if (en[ST_M4]) begin
      m4_sp_r <= shift_sat(95'(m3_x_r), m3_kp_r);
      m4_sg_r <= shift_sat(m3_xg_r, m3_kg_r);
      m4_vj_r <= m3_vj_r;
    end
  end

  // Output register: subtract the saturation current and clip.
  logic [63:0] big;
  logic [63:0] diff;
  logic [63:0] cur;
  logic [62:0] cond;

  assign big  = m4_sp_r[64] ? {64{1'b1}} : m4_sp_r[63:0];
  assign diff = big - 64'(is_r);
  assign cur  = (big >= 64'(is_r) && diff > 64'(LIMIT63)) ? 64'(LIMIT63) : diff;
  assign cond = (m4_sg_r[64] || m4_sg_r[63]) ? LIMIT63 : m4_sg_r[62:0];

  logic signed [24:0] out_vj_r;
  logic [63:0]        out_cur_r;
  logic [62:0]        out_cond_r;
  logic               out_sat_r;

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      out_vj_r   <= m4_vj_r;
      out_cur_r  <= cur;
      out_cond_r <= cond;
      out_sat_r  <= (cur == 64'(LIMIT63)) || (cond == LIMIT63);
    end
  end

  assign out_tdata = {out_cond_r, out_cur_r, out_vj_r};
  assign out_tuser = out_sat_r;

  `DCE_ASSERT_NEXT(a_in_enters, (in_tvalid && in_tready), v_r[0], "accepted request missing from first stage")
  `DCE_ASSERT_NOW(a_sat_flag, (out_tvalid && out_tuser), (out_cur_r == 64'(LIMIT63) || out_cond_r == LIMIT63), "saturation flag without a clipped value")
  `DCE_ASSERT_NEXT(a_stage_hold, (v_r[ST_M0] && !en[ST_M0]), (v_r[ST_M0] && $stable(m0_pl_r)), "stalled stage lost its request")

endmodule
